>>> design/per_id_motion_delta_matcher_top_macros.svh
// ---------------------------------------------------------------------------
// per_id_motion_delta_matcher_top_macros
// assertion helpers shared by the matcher rtl
// ---------------------------------------------------------------------------
`ifndef PER_ID_MOTION_DELTA_MATCHER_TOP_MACROS_SVH
`define PER_ID_MOTION_DELTA_MATCHER_TOP_MACROS_SVH

// plain property checked on every clock outside reset
`define PMDM_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle implication checked outside reset
`define PMDM_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/pmdm_pkg.sv
// ---------------------------------------------------------------------------
// pmdm_pkg
// shared constants and types of the per-id motion delta matcher
// ---------------------------------------------------------------------------
package pmdm_pkg;

  localparam int ID_COUNT       = 1024;
  localparam int ID_W           = 10;
  localparam int FRAME_CAPACITY = 4096;
  localparam int CNT_W          = 13;
  localparam int ENT_W          = 13;
  localparam int POS_W          = 16;
  localparam int DIF_W          = 17;
  localparam int DLT_W          = 7;
  localparam int LIM_W          = 6;
  localparam int OUT_MAX        = 63;
  localparam int SNAP_RESET     = 40;

  localparam int BG_MOD_X = 24;
  localparam int BG_MOD_Y = 28;
  // offsets are multiples of the modulus that make any difference positive
  localparam int OFF_X    = BG_MOD_X * 2731;
  localparam int OFF_Y    = BG_MOD_Y * 2341;
  localparam int RCP_SH   = 22;
  localparam int RCP_X    = (1 << RCP_SH) / BG_MOD_X + 1;
  localparam int RCP_Y    = (1 << RCP_SH) / BG_MOD_Y + 1;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_DRAW  = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [ENT_W-1:0] head;
    logic [ENT_W-1:0] tail;
  } q_word_t;

endpackage

>>> design/pmdm_delta.sv
// ---------------------------------------------------------------------------
// pmdm_delta
// wraps or snaps a position difference, multiply stage registered
// ---------------------------------------------------------------------------
module pmdm_delta
  import pmdm_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [DIF_W-1:0] dx,
  input  logic signed [DIF_W-1:0] dy,
  input  logic                    bg,
  input  logic [LIM_W-1:0]        lim,
  output logic [DLT_W-1:0]        dx_o,
  output logic [DLT_W-1:0]        dy_o
);

  logic [DIF_W:0]   ux, uy;
  logic [DIF_W:0]   ux_r, uy_r;
  logic [35:0]      px, py;
  logic [13:0]      qx_r, qy_r;
  logic signed [DIF_W-1:0] dx_r, dy_r;
  logic             bg_r;
  logic [LIM_W-1:0] lim_r;
  logic [DIF_W:0]   rx_full, ry_full;
  logic [4:0]       rx, ry;
  logic [DLT_W-1:0] wx, wy;
  logic [DIF_W:0]   ax, ay;
  logic             big;

  assign ux = ($signed({dx[DIF_W-1], dx}) + (DIF_W+1)'(OFF_X));
  assign uy = ($signed({dy[DIF_W-1], dy}) + (DIF_W+1)'(OFF_Y));
  assign px = 36'(ux) * 36'(RCP_X);
  assign py = 36'(uy) * 36'(RCP_Y);

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r  <= ux;
      uy_r  <= uy;
      qx_r  <= px[RCP_SH +: 14];
      qy_r  <= py[RCP_SH +: 14];
      dx_r  <= dx;
      dy_r  <= dy;
      bg_r  <= bg;
      lim_r <= lim;
    end
  end

  // remainder = u - q*m, always below the modulus
  assign rx_full = ux_r - (((DIF_W+1)'(qx_r) << 4) + ((DIF_W+1)'(qx_r) << 3));
  assign ry_full = uy_r - (((DIF_W+1)'(qy_r) << 5) - ((DIF_W+1)'(qy_r) << 2));
  assign rx = rx_full[4:0];
  assign ry = ry_full[4:0];
  assign wx = (rx >= 5'(BG_MOD_X / 2)) ? DLT_W'(rx) - DLT_W'(BG_MOD_X) : DLT_W'(rx);
  assign wy = (ry >= 5'(BG_MOD_Y / 2)) ? DLT_W'(ry) - DLT_W'(BG_MOD_Y) : DLT_W'(ry);

  assign ax  = dx_r[DIF_W-1] ? -{1'b1, dx_r} : {1'b0, dx_r};
  assign ay  = dy_r[DIF_W-1] ? -{1'b1, dy_r} : {1'b0, dy_r};
  assign big = (ax > (DIF_W+1)'(lim_r)) || (ay > (DIF_W+1)'(lim_r));

  always_comb begin
    if (bg_r) begin
      dx_o = wx;
      dy_o = wy;
    end else if (big) begin
      dx_o = '0;
      dy_o = '0;
    end else begin
      dx_o = dx_r[DLT_W-1:0];
      dy_o = dy_r[DLT_W-1:0];
    end
  end

endmodule

>>> design/per_id_motion_delta_matcher_top.sv
// ---------------------------------------------------------------------------
// per_id_motion_delta_matcher_top
// matches draw commands to last frame's commands of the same id, gives motion
// ---------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | tdata: object_id, pos_x, pos_y; tuser: cmd, is_background_row
//  out_    | out | tdata: delta_x, delta_y; tuser: matched, dropped
//  cfg_    | in  | data: snap_limit
//
// a draw command goes through accept, queue memory read, entry memory read and wrap
// arithmetic in order; the queue read-modify-write needs these steps, and no new request is taken until they end.
// a frame start flips the bank, then a pass over every id clears the new bank's queues.
// after reset a pass over every id clears both banks; no request is taken meanwhile.
// results wait in an output register; a stalled output holds the last stage.
`include "per_id_motion_delta_matcher_top_macros.svh"

module per_id_motion_delta_matcher_top
  import pmdm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // object_id, pos_x, pos_y, zero pad
  input  logic [1:0]  in_tuser,   // cmd, is_background_row
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // delta_x, delta_y, zero pad
  output logic [1:0]  out_tuser,  // matched, dropped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_QRD  = 2'd1;
  localparam logic [1:0] ST_ERD  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [7:0]       snap_r;
  logic             cur_r;
  logic [CNT_W-1:0] cnt_r [2];
  logic             clr_busy_r;
  logic [1:0]       clr_mask_r;
  logic [ID_W-1:0]  clr_idx_r;

  logic [ID_W-1:0]  id_r;
  logic [POS_W-1:0] px_r, py_r;
  logic             bg_r, store_r, tag_r, match_r;
  logic [ENT_W-1:0] slot_r, h_r, pq_tail_r;

  q_word_t          qmem0 [ID_COUNT];
  q_word_t          qmem1 [ID_COUNT];
  q_word_t          qrd_r [2];
  logic [31:0]      xymem [2*FRAME_CAPACITY];
  logic [ENT_W-1:0] nxmem [2*FRAME_CAPACITY];
  logic [31:0]      xy_rd_r;
  logic [ENT_W-1:0] nx_rd_r;

  logic             in_acc, draw_acc, frame_acc;
  logic [ID_W-1:0]  in_id;
  q_word_t          pq, cq;
  logic             do_match;

  logic             we [2];
  logic [ID_W-1:0]  wa [2];
  q_word_t          wd [2];

  logic signed [DIF_W-1:0] dx, dy;
  logic [DLT_W-1:0] dlt_x, dlt_y;
  logic [LIM_W-1:0] lim;
  logic             out_free;
  logic             out_tvalid_r, out_match_r, out_drop_r;
  logic [DLT_W-1:0] out_dx_r, out_dy_r;

  assign in_id     = in_tdata[ID_W-1:0];
  assign in_tready = (state_r == ST_IDLE) && !clr_busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign draw_acc  = in_acc && (in_tuser[0] == CMD_DRAW);
  assign frame_acc = in_acc && (in_tuser[0] == CMD_FRAME);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;

  assign pq       = qrd_r[!cur_r];
  assign cq       = qrd_r[cur_r];
  assign do_match = store_r && tag_r && pq.valid;

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = draw_acc ? ST_QRD : ST_IDLE;
      ST_QRD:  state_nxt = ST_ERD;
      ST_ERD:  state_nxt = ST_OUT;
      ST_OUT:  state_nxt = out_free ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      snap_r     <= 8'(SNAP_RESET);
      cur_r      <= 1'b0;
      cnt_r[0]   <= '0;
      cnt_r[1]   <= '0;
      clr_busy_r <= 1'b1;
      clr_mask_r <= 2'b11;
      clr_idx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        snap_r <= cfg_data;
      end
      if (frame_acc) begin
        cur_r             <= !cur_r;
        cnt_r[!cur_r]     <= '0;
        clr_busy_r        <= 1'b1;
        clr_mask_r        <= cur_r ? 2'b01 : 2'b10;
        clr_idx_r         <= '0;
      end else if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == ID_W'(ID_COUNT - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (state_r == ST_QRD && store_r) begin
        cnt_r[cur_r] <= cnt_r[cur_r] + 1'b1;
      end
    end
  end

  // capture the request and decide storage at accept
  always_ff @(posedge clk) begin
    if (draw_acc) begin
      id_r    <= in_id;
      px_r    <= in_tdata[ID_W +: POS_W];
      py_r    <= in_tdata[ID_W+POS_W +: POS_W];
      bg_r    <= in_tuser[1];
      store_r <= (cnt_r[cur_r] < CNT_W'(FRAME_CAPACITY));
      tag_r   <= (in_id != '0) && (32'(in_id) < ID_COUNT);
      slot_r  <= {cur_r, cnt_r[cur_r][ENT_W-2:0]};
    end
    if (state_r == ST_QRD) begin
      match_r   <= do_match;
      h_r       <= pq.head;
      pq_tail_r <= pq.tail;
    end
  end

  // queue memory write ports: clearing pass, tail append, head consume
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      we[b] = 1'b0;
      wa[b] = id_r;
      wd[b] = '0;
      if (clr_busy_r && clr_mask_r[b]) begin
        we[b] = 1'b1;
        wa[b] = clr_idx_r;
      end else if (state_r == ST_QRD && b == int'(cur_r)) begin
        we[b] = store_r && tag_r;
        wd[b] = cq.valid ? q_word_t'{valid: 1'b1, head: cq.head, tail: slot_r}
                         : q_word_t'{valid: 1'b1, head: slot_r, tail: slot_r};
      end else if (state_r == ST_ERD && b != int'(cur_r)) begin
        we[b] = match_r;
        wd[b] = (h_r == pq_tail_r) ? q_word_t'{valid: 1'b0, head: h_r, tail: pq_tail_r}
                                   : q_word_t'{valid: 1'b1, head: nx_rd_r, tail: pq_tail_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we[0]) begin
      qmem0[wa[0]] <= wd[0];
    end
    if (in_acc) begin
      qrd_r[0] <= qmem0[in_id];
    end
  end

  always_ff @(posedge clk) begin
    if (we[1]) begin
      qmem1[wa[1]] <= wd[1];
    end
    if (in_acc) begin
      qrd_r[1] <= qmem1[in_id];
    end
  end

  // entry stores: new entry at slot, link from current tail, read at prev head
  always_ff @(posedge clk) begin
    if (state_r == ST_QRD && store_r) begin
      xymem[slot_r] <= {py_r, px_r};
    end
    if (state_r == ST_QRD) begin
      xy_rd_r <= xymem[pq.head];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_QRD && store_r && tag_r && cq.valid) begin
      nxmem[cq.tail] <= slot_r;
    end
    if (state_r == ST_QRD) begin
      nx_rd_r <= nxmem[pq.head];
    end
  end

  assign dx  = $signed({px_r[POS_W-1], px_r}) - $signed({xy_rd_r[POS_W-1], xy_rd_r[POS_W-1:0]});
  assign dy  = $signed({py_r[POS_W-1], py_r})
             - $signed({xy_rd_r[2*POS_W-1], xy_rd_r[2*POS_W-1:POS_W]});
  assign lim = (snap_r > 8'(OUT_MAX)) ? LIM_W'(OUT_MAX) : snap_r[LIM_W-1:0];

  pmdm_delta u_delta (
    .clk  (clk),
    .en   (state_r == ST_ERD),
    .dx   (dx),
    .dy   (dy),
    .bg   (bg_r),
    .lim  (lim),
    .dx_o (dlt_x),
    .dy_o (dlt_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_dx_r    <= match_r ? dlt_x : '0;
      out_dy_r    <= match_r ? dlt_y : '0;
      out_match_r <= match_r;
      out_drop_r  <= !store_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_dy_r, out_dx_r};
  assign out_tuser  = {out_drop_r, out_match_r};

  `PMDM_CHECK(a_cnt0_cap, cnt_r[0] <= CNT_W'(FRAME_CAPACITY), "bank 0 count above capacity")
  `PMDM_CHECK(a_cnt1_cap, cnt_r[1] <= CNT_W'(FRAME_CAPACITY), "bank 1 count above capacity")
  `PMDM_CHECK(a_clr_no_req, !(clr_busy_r && in_tready), "request taken during clear pass")
  `PMDM_CHECK(a_flags, !(out_tvalid && out_tuser[0] && out_tuser[1]), "matched and dropped")
  `PMDM_NEXT(a_draw_seq, draw_acc, state_r == ST_QRD, "draw request did not start queue read")

endmodule

>>> tb/sv/per_id_motion_delta_matcher_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_id_motion_delta_matcher_top_tb
// streams draw commands and frame starts into the matcher and predicts the
// motion of each command against the same id's queue from the last frame;
// covers wrap, snap, untagged ids and snap limit settings under random gaps
// ----------------------------------------------------------------------------
module per_id_motion_delta_matcher_top_tb;
  import pmdm_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // object_id, pos_x, pos_y, zero pad
  logic [1:0]  in_tuser;   // cmd, is_background_row
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // delta_x, delta_y, zero pad
  logic [1:0]  out_tuser;  // matched, dropped
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  typedef struct {
    logic [DLT_W-1:0] dx;
    logic [DLT_W-1:0] dy;
    logic             matched;
    logic             dropped;
  } motion_t;

  class motion_scoreboard;
    motion_t     motion_q[$];
    int          errors;
    int          draws_seen;
    int          drops_seen;
    int          matches_seen;
    int          frames_seen;
    int          snap;
    logic [15:0] ent_x[2*FRAME_CAPACITY];
    logic [15:0] ent_y[2*FRAME_CAPACITY];
    int          ent_next[2*FRAME_CAPACITY];
    int          q_head[2*ID_COUNT];
    int          q_tail[2*ID_COUNT];
    bit          q_valid[2*ID_COUNT];
    int          bank;
    int          fill[2];

    function new();
      snap = SNAP_RESET;
      bank = 0;
      fill[0] = 0;
      fill[1] = 0;
      foreach (q_valid[i]) q_valid[i] = 0;
    endfunction

    function int wrap_period(int d, int m);
      int r;
      r = d % m;
      if (r < 0) r += m;
      if (r >= m / 2) r -= m;
      return r;
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d (draw %0d)", what, got, want, draws_seen);
      errors++;
    endtask

    function void note_input(bit cmd, int id, logic [15:0] px, logic [15:0] py, bit bg);
      motion_t m;
      int prv, slot, pq, cq, h, dx, dy, lim;
      prv = bank ^ 1;
      dx = 0;
      dy = 0;
      m.matched = 0;
      m.dropped = 0;
      if (cmd == CMD_FRAME) begin
        bank = prv;
        fill[prv] = 0;
        for (int i = 0; i < ID_COUNT; i++) q_valid[prv*ID_COUNT + i] = 0;
        frames_seen++;
        return;
      end
      if (fill[bank] >= FRAME_CAPACITY) begin
        m.dropped = 1;
      end else begin
        slot = bank * FRAME_CAPACITY + fill[bank];
        fill[bank]++;
        ent_x[slot] = px;
        ent_y[slot] = py;
        if (id != 0 && id < ID_COUNT) begin
          pq = prv * ID_COUNT + id;
          cq = bank * ID_COUNT + id;
          if (q_valid[pq]) begin
            h = q_head[pq];
            m.matched = 1;
            dx = int'($signed(px)) - int'($signed(ent_x[h]));
            dy = int'($signed(py)) - int'($signed(ent_y[h]));
            if (h == q_tail[pq]) q_valid[pq] = 0;
            else q_head[pq] = ent_next[h];
            if (bg) begin
              dx = wrap_period(dx, BG_MOD_X);
              dy = wrap_period(dy, BG_MOD_Y);
            end else begin
              lim = (snap > OUT_MAX) ? OUT_MAX : snap;
              if (dx > lim || -dx > lim || dy > lim || -dy > lim) begin
                dx = 0;
                dy = 0;
              end
            end
          end
          if (q_valid[cq]) begin
            ent_next[q_tail[cq]] = slot;
            q_tail[cq] = slot;
          end else begin
            q_head[cq] = slot;
            q_tail[cq] = slot;
            q_valid[cq] = 1;
          end
        end
      end
      m.dx = dx[DLT_W-1:0];
      m.dy = dy[DLT_W-1:0];
      motion_q.push_back(m);
    endfunction

    task check_result(logic [15:0] data, logic [1:0] user);
      motion_t m;
      draws_seen++;
      if (motion_q.size() == 0) begin
        report_mismatch("unexpected result", data, 0);
        return;
      end
      m = motion_q.pop_front();
      if (data[6:0] !== m.dx) report_mismatch("delta_x", data[6:0], m.dx);
      if (data[13:7] !== m.dy) report_mismatch("delta_y", data[13:7], m.dy);
      if (user[0] !== m.matched) report_mismatch("matched", user[0], m.matched);
      if (user[1] !== m.dropped) report_mismatch("dropped", user[1], m.dropped);
      if (m.matched) matches_seen++;
      if (m.dropped) drops_seen++;
    endtask
  endclass

  motion_scoreboard sb;
  int idle_pct;
  int stall_pct;
  bit hold_start;
  int hold_cnt;

  per_id_motion_delta_matcher_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // watch both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_input(in_tuser[0], in_tdata[9:0], in_tdata[25:10], in_tdata[41:26],
                      in_tuser[1]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  // result side backpressure, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_start) begin
      hold_start = 0;
      hold_cnt = 400;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_request(bit cmd, int id, int px, int py, bit bg);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {bg, cmd};
    in_tdata  <= {6'd0, py[15:0], px[15:0], id[9:0]};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.motion_q.size() > 0) @(posedge clk);
  endtask

  // a frame clear gives no result, so wait it out before writing the limit
  task automatic write_snap(int v);
    wait_drained();
    repeat (1100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v[7:0];
    do @(posedge clk); while (!cfg_ready);
    sb.snap = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_draws(int n);
    int id, base_x, base_y, px, py;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(11) == 0) begin
        send_request(CMD_FRAME, $urandom_range(1023), $urandom, $urandom, $urandom_range(1));
        continue;
      end
      id = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(29) == 0) id = $urandom_range(1023);
      base_x = id * 37;
      base_y = -id * 53;
      if ($urandom_range(7) == 0) begin
        px = $urandom;
        py = $urandom;
      end else begin
        px = base_x + $urandom_range(100) - 50;
        py = base_y + $urandom_range(100) - 50;
      end
      send_request(CMD_DRAW, id, px, py, ($urandom_range(3) == 0));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 0;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_start = 0;
    hold_cnt = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, untagged, fifo order, wrap and snap
    send_request(CMD_DRAW, 0, 32767, -32768, 0);
    send_request(CMD_DRAW, 1023, -32768, 32767, 1);
    send_request(CMD_DRAW, 5, 100, 100, 0);
    send_request(CMD_DRAW, 5, 200, 200, 0);
    send_request(CMD_DRAW, 6, 0, 0, 1);
    send_request(CMD_DRAW, 7, 0, 0, 0);
    send_request(CMD_FRAME, 0, 0, 0, 0);
    send_request(CMD_DRAW, 1023, 32767, -32768, 1);
    send_request(CMD_DRAW, 5, 140, 60, 0);
    send_request(CMD_DRAW, 5, 241, 200, 0);
    send_request(CMD_DRAW, 5, 0, 0, 0);
    send_request(CMD_DRAW, 6, -13, 27, 1);
    send_request(CMD_DRAW, 7, 40, -40, 0);
    send_request(CMD_DRAW, 9, 1, 1, 0);
    send_request(CMD_DRAW, 0, 1, 1, 0);
    send_request(CMD_FRAME, 1023, -1, -1, 1);
    send_request(CMD_DRAW, 7, 12, 14, 1);
    send_request(CMD_DRAW, 5, 140 + 63, 60 - 63, 0);

    send_request(CMD_FRAME, 0, 0, 0, 0);
    random_draws(40);

    write_snap(0);
    random_draws(300);
    hold_start = 1;
    random_draws(60);

    write_snap(255);
    idle_pct = 58;
    random_draws(150);
    wait_drained();
    random_draws(200);

    write_snap(63);
    idle_pct = 0;
    stall_pct = 58;
    random_draws(350);

    write_snap(64);
    idle_pct = 18;
    stall_pct = 18;
    random_draws(150);
    write_snap($urandom_range(255));
    random_draws(200);

    wait_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d draws, %0d frame starts, %0d matched, %0d dropped",
             sb.draws_seen, sb.frames_seen, sb.matches_seen, sb.drops_seen);
    if (sb.errors == 0 && sb.motion_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout waiting for results");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
